[hw/rtl/daae_pkg.sv]
// shared types, constants and phase codes for the dns answer address extractor
// used by daae_parser and dns_answer_address_extractor
package daae_pkg;

  localparam int MAX_PACKET_DEF = 512;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [3:0]  HDR_LEN    = 4'd12;
  localparam logic [3:0]  RR_FIXED   = 4'd10;
  localparam logic [3:0]  ADDR_BYTES = 4'd4;
  localparam logic [3:0]  QFIX_BYTES = 4'd4;
  localparam logic [15:0] FLAG_QR    = 16'h8000;
  localparam logic [15:0] FLAG_RCODE = 16'h000F;
  localparam logic [15:0] TYPE_A     = 16'd1;
  localparam logic [15:0] A_RDLEN    = 16'd4;
  localparam logic [7:0]  PTR_MASK   = 8'hC0;
  localparam logic [7:0]  LABEL_MASK = 8'h3F;

  localparam logic [2:0] ST_FOUND        = 3'd0;
  localparam logic [2:0] ST_SHORT        = 3'd1;
  localparam logic [2:0] ST_ID_MISMATCH  = 3'd2;
  localparam logic [2:0] ST_NOT_RESPONSE = 3'd3;
  localparam logic [2:0] ST_RCODE_ERROR  = 3'd4;
  localparam logic [2:0] ST_NO_ANSWERS   = 3'd5;
  localparam logic [2:0] ST_NO_A_RECORD  = 3'd6;

  localparam logic [APB_ADDR_W-1:0] REG_EXPECTED_ID = 3'd0;

  typedef enum logic [3:0] {
    PH_HEADER = 4'd0,
    PH_QNAME  = 4'd1,
    PH_QPTR   = 4'd2,
    PH_QFIXED = 4'd3,
    PH_ANAME  = 4'd4,
    PH_APTR   = 4'd5,
    PH_AFIXED = 4'd6,
    PH_RDATA  = 4'd7,
    PH_ADDR   = 4'd8,
    PH_DONE   = 4'd9
  } phase_t;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic       final_byte;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] address;
  } out_beat_t;

endpackage

[hw/rtl/daae_parser.sv]
// byte-at-a-time dns response walker: header checks, name skipping, answer scan
// depends on daae_pkg
module daae_parser #(
  parameter int MAX_PACKET = daae_pkg::MAX_PACKET_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  daae_pkg::in_beat_t  beat,
  input  logic [15:0]         expected_id,
  output logic                res_valid,
  output daae_pkg::out_beat_t res
);

  localparam int POS_W = $clog2(MAX_PACKET + 1);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_PACKET);

  daae_pkg::phase_t phase, phase_upd, phase_next;
  logic [POS_W-1:0] byte_position, pos_upd, pos_next;
  logic [15:0] header_flags, flags_upd, flags_next;
  logic [15:0] questions_left, q_upd, q_next;
  logic [15:0] answers_left, a_upd, a_next;
  logic [15:0] skip_left, skip_upd, skip_next;
  logic [3:0]  field_index, fidx_upd, fidx_next;
  logic [15:0] record_type, rtype_upd, rtype_next;
  logic [15:0] record_length, rlen_upd, rlen_next;
  logic [31:0] address_build, ab_upd, ab_next;
  logic [31:0] found_address, found_upd, found_next;
  logic [2:0]  outcome, outcome_upd, outcome_next;
  logic [7:0]  b;
  logic [3:0]  fidx_inc;
  logic [15:0] q_dec;
  logic [15:0] skip_dec;
  logic        in_range;
  logic [2:0]  st;

  assign b        = beat.packet_byte;
  assign fidx_inc = field_index + 4'd1;
  assign q_dec    = questions_left - 16'd1;
  assign in_range = byte_position < POS_MAX;

  always_comb begin
    phase_upd   = phase;
    pos_upd     = byte_position;
    flags_upd   = header_flags;
    q_upd       = questions_left;
    a_upd       = answers_left;
    skip_upd    = skip_left;
    fidx_upd    = field_index;
    rtype_upd   = record_type;
    rlen_upd    = record_length;
    ab_upd      = address_build;
    found_upd   = found_address;
    outcome_upd = outcome;
    skip_dec    = (skip_left != 16'd0) ? skip_left - 16'd1 : skip_left;
    if (in_range) begin
      pos_upd = byte_position + POS_W'(1);
      unique case (phase) inside
        daae_pkg::PH_HEADER: begin
          if (byte_position < POS_W'(2)) rtype_upd = {record_type[7:0], b};
          else if (byte_position < POS_W'(4)) flags_upd = {header_flags[7:0], b};
          else if (byte_position < POS_W'(6)) q_upd = {questions_left[7:0], b};
          else if (byte_position < POS_W'(8)) a_upd = {answers_left[7:0], b};
          if (byte_position == POS_W'(daae_pkg::HDR_LEN - 4'd1)) begin
            if (record_type != expected_id) begin
              outcome_upd = daae_pkg::ST_ID_MISMATCH;
              phase_upd   = daae_pkg::PH_DONE;
            end else if ((header_flags & daae_pkg::FLAG_QR) == 16'd0) begin
              outcome_upd = daae_pkg::ST_NOT_RESPONSE;
              phase_upd   = daae_pkg::PH_DONE;
            end else if ((header_flags & daae_pkg::FLAG_RCODE) != 16'd0) begin
              outcome_upd = daae_pkg::ST_RCODE_ERROR;
              phase_upd   = daae_pkg::PH_DONE;
            end else if (answers_left == 16'd0) begin
              outcome_upd = daae_pkg::ST_NO_ANSWERS;
              phase_upd   = daae_pkg::PH_DONE;
            end else begin
              rtype_upd = 16'd0;
              phase_upd = (questions_left == 16'd0) ? daae_pkg::PH_ANAME
                                                    : daae_pkg::PH_QNAME;
            end
          end
        end
        daae_pkg::PH_QNAME, daae_pkg::PH_ANAME: begin
          if (skip_left != 16'd0) begin
            skip_upd = skip_left - 16'd1;
          end else begin
            fidx_upd = 4'd0;
            if (b == 8'd0) begin
              phase_upd = (phase == daae_pkg::PH_QNAME) ? daae_pkg::PH_QFIXED
                                                        : daae_pkg::PH_AFIXED;
            end else if ((b & daae_pkg::PTR_MASK) == daae_pkg::PTR_MASK) begin
              phase_upd = (phase == daae_pkg::PH_QNAME) ? daae_pkg::PH_QPTR
                                                        : daae_pkg::PH_APTR;
            end else begin
              skip_upd = {8'd0, b & daae_pkg::LABEL_MASK};
            end
          end
        end
        daae_pkg::PH_QPTR: begin
          fidx_upd  = 4'd0;
          phase_upd = daae_pkg::PH_QFIXED;
        end
        daae_pkg::PH_APTR: begin
          fidx_upd  = 4'd0;
          phase_upd = daae_pkg::PH_AFIXED;
        end
        daae_pkg::PH_QFIXED: begin
          fidx_upd = fidx_inc;
          if (fidx_inc >= daae_pkg::QFIX_BYTES) begin
            fidx_upd  = 4'd0;
            q_upd     = q_dec;
            phase_upd = (q_dec == 16'd0) ? daae_pkg::PH_ANAME : daae_pkg::PH_QNAME;
          end
        end
        daae_pkg::PH_AFIXED: begin
          if (field_index < 4'd2) rtype_upd = {record_type[7:0], b};
          else if (field_index >= 4'd8) rlen_upd = {record_length[7:0], b};
          fidx_upd = fidx_inc;
          if (fidx_inc >= daae_pkg::RR_FIXED) begin
            fidx_upd = 4'd0;
            if (rtype_upd == daae_pkg::TYPE_A && rlen_upd == daae_pkg::A_RDLEN) begin
              ab_upd    = 32'd0;
              phase_upd = daae_pkg::PH_ADDR;
            end else if (answers_left <= 16'd1) begin
              outcome_upd = daae_pkg::ST_NO_A_RECORD;
              phase_upd   = daae_pkg::PH_DONE;
            end else begin
              a_upd     = answers_left - 16'd1;
              skip_upd  = rlen_upd;
              phase_upd = (rlen_upd == 16'd0) ? daae_pkg::PH_ANAME : daae_pkg::PH_RDATA;
            end
          end
        end
        daae_pkg::PH_RDATA: begin
          skip_upd = skip_dec;
          if (skip_dec == 16'd0) phase_upd = daae_pkg::PH_ANAME;
        end
        daae_pkg::PH_ADDR: begin
          ab_upd   = {address_build[23:0], b};
          fidx_upd = fidx_inc;
          if (fidx_inc >= daae_pkg::ADDR_BYTES) begin
            found_upd   = ab_upd;
            outcome_upd = daae_pkg::ST_FOUND;
            phase_upd   = daae_pkg::PH_DONE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // result of the message on its last byte
  always_comb begin
    if (phase_upd == daae_pkg::PH_DONE) st = outcome_upd;
    else if (phase_upd == daae_pkg::PH_ADDR && a_upd <= 16'd1) st = daae_pkg::ST_NO_A_RECORD;
    else st = daae_pkg::ST_SHORT;
    res_valid   = take && beat.final_byte;
    res.status  = st;
    res.address = (st == daae_pkg::ST_FOUND) ? found_upd : 32'd0;
  end

  // back to the reset state after the last byte
  always_comb begin
    if (beat.final_byte) begin
      phase_next   = daae_pkg::PH_HEADER;
      pos_next     = '0;
      flags_next   = '0;
      q_next       = '0;
      a_next       = '0;
      skip_next    = '0;
      fidx_next    = '0;
      rtype_next   = '0;
      rlen_next    = '0;
      ab_next      = '0;
      found_next   = '0;
      outcome_next = '0;
    end else begin
      phase_next   = phase_upd;
      pos_next     = pos_upd;
      flags_next   = flags_upd;
      q_next       = q_upd;
      a_next       = a_upd;
      skip_next    = skip_upd;
      fidx_next    = fidx_upd;
      rtype_next   = rtype_upd;
      rlen_next    = rlen_upd;
      ab_next      = ab_upd;
      found_next   = found_upd;
      outcome_next = outcome_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= daae_pkg::PH_HEADER;
      byte_position  <= '0;
      header_flags   <= '0;
      questions_left <= '0;
      answers_left   <= '0;
      skip_left      <= '0;
      field_index    <= '0;
      record_type    <= '0;
      record_length  <= '0;
      address_build  <= '0;
      found_address  <= '0;
      outcome        <= '0;
    end else if (take) begin
      phase          <= phase_next;
      byte_position  <= pos_next;
      header_flags   <= flags_next;
      questions_left <= q_next;
      answers_left   <= a_next;
      skip_left      <= skip_next;
      field_index    <= fidx_next;
      record_type    <= rtype_next;
      record_length  <= rlen_next;
      address_build  <= ab_next;
      found_address  <= found_next;
      outcome        <= outcome_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    byte_position <= POS_MAX)
    else $error("byte position past packet limit");

  a_header_pos: assert property (@(posedge clk) disable iff (rst)
    phase != daae_pkg::PH_HEADER |-> byte_position >= POS_W'(daae_pkg::HDR_LEN))
    else $error("left header phase before twelve bytes");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    take && beat.final_byte |=> phase == daae_pkg::PH_HEADER && byte_position == '0)
    else $error("state not cleared after last byte");

  a_addr_only_found: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status != daae_pkg::ST_FOUND |-> res.address == 32'd0)
    else $error("address given without a found status");

  a_addr_index: assert property (@(posedge clk) disable iff (rst)
    phase == daae_pkg::PH_ADDR |-> field_index < daae_pkg::ADDR_BYTES)
    else $error("address byte index out of range");
`endif

endmodule

[hw/rtl/dns_answer_address_extractor.sv]
// top level: byte input channel, result channel, apb register for the expected id
// depends on daae_pkg and daae_parser
//
// usage:
//   feed a dns response one byte per beat on in_beat (packet_byte, final_byte
//   set on the last byte of the message); one result beat on out_beat
//   (status, address) follows each message
//   expected_id is written through the apb port at byte address 0 while idle
// output: the result is valid in the cycle after the final byte is accepted
// throughput: one byte per cycle while in_ready is high; every byte updates the parser state
//   combinationally between the parser registers and the result register
// stall: the result register holds while out_ready is low; in_ready stays high
//   as long as the result register is empty or being drained in that cycle
// reset: rst is synchronous; the parser returns to the header phase, the
//   result register empties and expected_id clears to zero
// after each final byte the parser clears itself and takes the next message
module dns_answer_address_extractor #(
  parameter int MAX_PACKET = daae_pkg::MAX_PACKET_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  daae_pkg::in_beat_t                  in_beat,
  output logic                                out_valid,
  input  logic                                out_ready,
  output daae_pkg::out_beat_t                 out_beat,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [daae_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [daae_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [daae_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);

  logic                expected_id_hit;
  logic [15:0]         expected_id;
  logic                take;
  logic                res_valid;
  daae_pkg::out_beat_t res;

  assign pready          = 1'b1;
  assign expected_id_hit = paddr == daae_pkg::REG_EXPECTED_ID;
  assign prdata          = expected_id_hit ? {16'd0, expected_id} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_id <= '0;
    end else if (psel && penable && pwrite && expected_id_hit) begin
      expected_id <= pwdata[15:0];
    end
  end

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  daae_parser #(
    .MAX_PACKET(MAX_PACKET)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .beat       (in_beat),
    .expected_id(expected_id),
    .res_valid  (res_valid),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_beat <= res;
    end
  end

endmodule
